[design/bpu_pkg.sv]
// Shared types, register indexes and constants for the BMP pixel unpacker.
package bpu_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int BPP_W = 3;
    localparam int SIZE_W = 13;
    localparam int WORD_W = 32;
    localparam int SHIFT_W = 5;
    localparam int CHAN_W = 8;

    // Configuration register indexes, in port order.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BPP        = 3'd0,
        REG_WIDTH      = 3'd1,
        REG_HEIGHT     = 3'd2,
        REG_RED_MASK   = 3'd3,
        REG_GREEN_MASK = 3'd4,
        REG_BLUE_MASK  = 3'd5,
        REG_ALPHA_MASK = 3'd6
    } cfg_reg_t;

    localparam logic [BPP_W-1:0] BPP_MIN = 3'd2;
    localparam logic [BPP_W-1:0] BPP_MAX = 3'd4;
    localparam logic [BPP_W-1:0] BPP_16 = 3'd2;

    localparam logic [WORD_W-1:0] DEF16_RED = 32'h0000_7C00;
    localparam logic [WORD_W-1:0] DEF16_GREEN = 32'h0000_03E0;
    localparam logic [WORD_W-1:0] DEF16_BLUE = 32'h0000_001F;
    localparam logic [WORD_W-1:0] DEF24_RED = 32'h00FF_0000;
    localparam logic [WORD_W-1:0] DEF24_GREEN = 32'h0000_FF00;
    localparam logic [WORD_W-1:0] DEF24_BLUE = 32'h0000_00FF;

    // Raw geometry registers, clamped where they are used.
    typedef struct packed {
        logic [BPP_W-1:0]  bpp;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } geom_t;

    // One channel: effective mask and its trailing-zero count.
    typedef struct packed {
        logic [WORD_W-1:0]  mask;
        logic [SHIFT_W-1:0] shift;
    } chan_sel_t;

    typedef struct packed {
        chan_sel_t red;
        chan_sel_t green;
        chan_sel_t blue;
        chan_sel_t alpha;
    } extract_t;

    // One assembled pixel on its way to channel extraction.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              row_end;
        logic              image_end;
    } pixel_t;

    function automatic logic [BPP_W-1:0] bpp_clamp(input logic [BPP_W-1:0] raw);
        logic [BPP_W-1:0] res;
        if (raw < BPP_MIN)
        begin
            res = BPP_MIN;
        end
        else if (raw > BPP_MAX)
        begin
            res = BPP_MAX;
        end
        else
        begin
            res = raw;
        end
        return res;
    endfunction

endpackage

[design/bpu_cfg_regs.sv]
// Configuration registers and the registered effective channel masks and shifts.
module bpu_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [bpu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpu_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bpu_pkg::geom_t                   geom,
    output bpu_pkg::extract_t                ext
);
    import bpu_pkg::*;

    logic [BPP_W-1:0]  bpp_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [WORD_W-1:0] red_mask_reg;
    logic [WORD_W-1:0] green_mask_reg;
    logic [WORD_W-1:0] blue_mask_reg;
    logic [WORD_W-1:0] alpha_mask_reg;
    extract_t          ext_reg;
    extract_t          ext_next;

    // Lowest set bit position; a zero mask yields the top position, and it
    // then selects nothing anyway.
    function automatic logic [SHIFT_W-1:0] trailing_zeros(input logic [WORD_W-1:0] m);
        logic [SHIFT_W-1:0] tz;
        tz = SHIFT_W'(WORD_W - 1);
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                tz = SHIFT_W'(i);
            end
        end
        return tz;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg        <= 3'd3;
            width_reg      <= 13'd1;
            height_reg     <= 13'd1;
            red_mask_reg   <= '0;
            green_mask_reg <= '0;
            blue_mask_reg  <= '0;
            alpha_mask_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BPP:        bpp_reg        <= cfg_data[BPP_W-1:0];
                REG_WIDTH:      width_reg      <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT:     height_reg     <= cfg_data[SIZE_W-1:0];
                REG_RED_MASK:   red_mask_reg   <= cfg_data;
                REG_GREEN_MASK: green_mask_reg <= cfg_data;
                REG_BLUE_MASK:  blue_mask_reg  <= cfg_data;
                REG_ALPHA_MASK: alpha_mask_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // A missing RGB mask falls back to the default set for the depth.
    always_comb
    begin
        logic use_default;
        use_default = (red_mask_reg == '0) || (green_mask_reg == '0) || (blue_mask_reg == '0);
        ext_next.red.mask   = red_mask_reg;
        ext_next.green.mask = green_mask_reg;
        ext_next.blue.mask  = blue_mask_reg;
        ext_next.alpha.mask = alpha_mask_reg;
        if (use_default)
        begin
            if (bpp_clamp(bpp_reg) == BPP_16)
            begin
                ext_next.red.mask   = DEF16_RED;
                ext_next.green.mask = DEF16_GREEN;
                ext_next.blue.mask  = DEF16_BLUE;
            end
            else
            begin
                ext_next.red.mask   = DEF24_RED;
                ext_next.green.mask = DEF24_GREEN;
                ext_next.blue.mask  = DEF24_BLUE;
            end
        end
        ext_next.red.shift   = trailing_zeros(ext_next.red.mask);
        ext_next.green.shift = trailing_zeros(ext_next.green.mask);
        ext_next.blue.shift  = trailing_zeros(ext_next.blue.mask);
        ext_next.alpha.shift = trailing_zeros(ext_next.alpha.mask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg.red.mask    <= DEF24_RED;
            ext_reg.red.shift   <= 5'd16;
            ext_reg.green.mask  <= DEF24_GREEN;
            ext_reg.green.shift <= 5'd8;
            ext_reg.blue.mask   <= DEF24_BLUE;
            ext_reg.blue.shift  <= 5'd0;
            ext_reg.alpha.mask  <= '0;
            ext_reg.alpha.shift <= SHIFT_W'(WORD_W - 1);
        end
        else
        begin
            ext_reg <= ext_next;
        end
    end

    assign geom.bpp    = bpp_reg;
    assign geom.width  = width_reg;
    assign geom.height = height_reg;
    assign ext         = ext_reg;

`ifndef SYNTHESIS
    a_red_shift_hits_lsb: assert property (@(posedge clk) disable iff (!rst_n)
        ext_reg.red.mask != '0 |-> ext_reg.red.mask[ext_reg.red.shift])
        else $error("red shift does not land on the mask's lowest set bit");

    a_alpha_shift_hits_lsb: assert property (@(posedge clk) disable iff (!rst_n)
        ext_reg.alpha.mask != '0 |-> ext_reg.alpha.mask[ext_reg.alpha.shift])
        else $error("alpha shift does not land on the mask's lowest set bit");
`endif

endmodule

[design/bpu_assembler.sv]
// Byte assembly, row padding skip and row/image position tracking.
module bpu_assembler #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  data_byte,
    input  bpu_pkg::geom_t              geom,
    output logic                        pix_valid,
    input  logic                        pix_ready,
    output bpu_pkg::pixel_t             pix
);
    import bpu_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int COL_LIM_W = COL_W + 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ROW_LIM_W = ROW_W + 1;

    logic [WORD_W-1:0]    pixel_word_reg, pixel_word_next;
    logic [1:0]           byte_index_reg, byte_index_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [1:0]           pad_reg, pad_next;
    logic                 pix_valid_reg, pix_valid_next;
    pixel_t               pix_reg, pix_next;

    logic [BPP_W-1:0]     bpp_eff;
    logic [COL_LIM_W-1:0] width_eff;
    logic [ROW_LIM_W-1:0] height_eff;
    logic                 in_fire;
    logic [WORD_W-1:0]    word_new;
    logic [1:0]           index_inc;
    logic                 pixel_done;
    logic                 row_done;
    logic                 image_done;
    logic [1:0]           row_bytes_low;

    assign bpp_eff = bpp_clamp(geom.bpp);

    always_comb
    begin
        if (geom.width == '0)
        begin
            width_eff = COL_LIM_W'(1);
        end
        else if (32'(geom.width) > 32'(MAX_WIDTH))
        begin
            width_eff = COL_LIM_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = COL_LIM_W'(geom.width);
        end

        if (geom.height == '0)
        begin
            height_eff = ROW_LIM_W'(1);
        end
        else if (32'(geom.height) > 32'(MAX_HEIGHT))
        begin
            height_eff = ROW_LIM_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = ROW_LIM_W'(geom.height);
        end
    end

    assign in_ready = !pix_valid_reg || pix_ready;
    assign in_fire  = in_valid && in_ready;

    assign word_new   = pixel_word_reg | (WORD_W'(data_byte) << {byte_index_reg, 3'b000});
    assign index_inc  = byte_index_reg + 2'd1;
    assign pixel_done = (index_inc == 2'd0) || ({1'b0, index_inc} >= bpp_eff);
    assign row_done   = ({1'b0, col_reg} + COL_LIM_W'(1)) >= width_eff;
    assign image_done = row_done && (({1'b0, row_reg} + ROW_LIM_W'(1)) >= height_eff);

    // Only the low two bits of width times depth decide the row padding.
    assign row_bytes_low = 2'(width_eff[1:0] * bpp_eff[1:0]);

    always_comb
    begin
        pixel_word_next = pixel_word_reg;
        byte_index_next = byte_index_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pad_next        = pad_reg;
        pix_valid_next  = pix_valid_reg && !pix_ready;
        pix_next        = pix_reg;

        if (in_fire)
        begin
            if (pad_reg != 2'd0)
            begin
                pad_next = pad_reg - 2'd1;
            end
            else if (!pixel_done)
            begin
                pixel_word_next = word_new;
                byte_index_next = index_inc;
            end
            else
            begin
                pixel_word_next    = '0;
                byte_index_next    = 2'd0;
                pix_valid_next     = 1'b1;
                pix_next.word      = word_new;
                pix_next.row_end   = row_done;
                pix_next.image_end = image_done;
                if (row_done)
                begin
                    col_next = '0;
                    pad_next = 2'(2'd0 - row_bytes_low);
                    if (image_done)
                    begin
                        row_next = '0;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_word_reg <= '0;
            byte_index_reg <= 2'd0;
            col_reg        <= '0;
            row_reg        <= '0;
            pad_reg        <= 2'd0;
            pix_valid_reg  <= 1'b0;
        end
        else
        begin
            pixel_word_reg <= pixel_word_next;
            byte_index_reg <= byte_index_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            pad_reg        <= pad_next;
            pix_valid_reg  <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

`ifndef SYNTHESIS
    a_pad_between_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg != 2'd0 |-> byte_index_reg == 2'd0 && pixel_word_reg == '0)
        else $error("padding skip overlaps a partly assembled pixel");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_reg} < COL_LIM_W'(MAX_WIDTH))
        else $error("column position beyond the maximum width");

    a_pixel_held: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid_reg && !pix_ready |=> pix_valid_reg && $stable(pix_reg))
        else $error("assembled pixel lost while extraction stage was stalled");
`endif

endmodule

[design/bpu_extract.sv]
// Channel extraction from an assembled pixel word into the output register.
module bpu_extract (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_ready,
    input  bpu_pkg::pixel_t      pix,
    input  bpu_pkg::extract_t    ext,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue,
    output logic [7:0]           alpha,
    output logic                 row_end,
    output logic                 image_end
);
    import bpu_pkg::*;

    logic              out_valid_reg;
    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic              row_end_reg, image_end_reg;
    logic              load;

    function automatic logic [CHAN_W-1:0] channel(input logic [WORD_W-1:0] word,
                                                  input chan_sel_t sel);
        logic [WORD_W-1:0] shifted;
        shifted = (word & sel.mask) >> sel.shift;
        return shifted[CHAN_W-1:0];
    endfunction

    assign pix_ready = !out_valid_reg || out_ready;
    assign load      = pix_valid && pix_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pix_ready)
        begin
            out_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg       <= channel(pix.word, ext.red);
            green_reg     <= channel(pix.word, ext.green);
            blue_reg      <= channel(pix.word, ext.blue);
            alpha_reg     <= channel(pix.word, ext.alpha);
            row_end_reg   <= pix.row_end;
            image_end_reg <= pix.image_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign alpha     = alpha_reg;
    assign row_end   = row_end_reg;
    assign image_end = image_end_reg;

endmodule

[design/bmp_pixel_unpacker.sv]
// A pixel request passes the assembly pixel register and then the output register.
// Throughput: one byte per cycle unless stalled, padding too; at most one pixel per cycle out.
// The byte assembly register sets the rate: it takes a byte when free or being drained.
// Reset (rst_n, asynchronous, active low) clears position, padding and pipeline valids;
// registers return to 3 bytes per pixel, 1 x 1 image and all-zero masks.
// Geometry writes apply once registered; mask writes also pass the registered effective masks.
module bmp_pixel_unpacker #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [bpu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpu_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       data_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       red,
    output logic [7:0]                       green,
    output logic [7:0]                       blue,
    output logic [7:0]                       alpha,
    output logic                             row_end,
    output logic                             image_end
);
    import bpu_pkg::*;

    // Raw geometry goes straight to the assembler, which clamps it. The
    // effective masks and their shifts are registered in the config block
    // so that the extraction stage sees only an AND and a barrel shift.
    geom_t    geom;
    extract_t ext;

    // Assembled pixel request between the two stages. Each stage holds its
    // request while the next one stalls, so a byte is accepted whenever the
    // assembly register is free or is being drained in the same cycle.
    logic     pix_valid;
    logic     pix_ready;
    pixel_t   pix;

    bpu_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom),
        .ext       (ext)
    );

    // Packs bytes little-endian into the pixel word, skips the row padding
    // and tags each pixel with its row and image end flags.
    bpu_assembler #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_asm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .geom      (geom),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    // Masks and shifts the four channels into the output register.
    bpu_extract u_ext (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .ext       (ext),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha),
        .row_end   (row_end),
        .image_end (image_end)
    );

endmodule
